[src/chf_pkg.sv]
// ----------------------------------------------------------------------------
// chf_pkg
// Shared widths, constants and record types of the clipping half-wave finder.
// ----------------------------------------------------------------------------
package chf_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int INDEX_BITS  = 32;
    localparam int THRESH_BITS = SAMPLE_BITS - 1;

    localparam logic [THRESH_BITS-1:0] THRESH_RESET = THRESH_BITS'(1 << 20);
    localparam logic [INDEX_BITS-1:0]  IDX_MAX      = '1;

    localparam int QDEPTH   = 4;
    localparam int QPTR_BITS = $clog2(QDEPTH);
    localparam int QCNT_BITS = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [INDEX_BITS-1:0]  start_idx;
        logic [INDEX_BITS-1:0]  peak_idx;
        logic [INDEX_BITS-1:0]  end_idx;
        logic [SAMPLE_BITS-1:0] peak_mag;
    } t_rec;

    typedef struct packed {
        logic cross_vld;
        logic end_vld;
        t_rec cross_rec;
        t_rec end_rec;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

[src/chf_in_if.sv]
// ----------------------------------------------------------------------------
// chf_in_if
// Sample channel: one sample and its end-of-channel flag per beat.
// ----------------------------------------------------------------------------
interface chf_in_if import chf_pkg::*; ();

    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last_sample;

    modport source (output valid, output sample, output last_sample, input ready);
    modport sink   (input valid, input sample, input last_sample, output ready);

endinterface

[src/chf_out_if.sv]
// ----------------------------------------------------------------------------
// chf_out_if
// Record channel: one clipping half-wave record per beat.
// ----------------------------------------------------------------------------
interface chf_out_if import chf_pkg::*; ();

    logic                   valid;
    logic                   ready;
    logic [INDEX_BITS-1:0]  halfwave_start;
    logic [INDEX_BITS-1:0]  peak_index;
    logic [INDEX_BITS-1:0]  halfwave_end;
    logic [SAMPLE_BITS-1:0] peak_magnitude;
    logic                   last_in_run;

    modport source (output valid, output halfwave_start, output peak_index,
                    output halfwave_end, output peak_magnitude, output last_in_run,
                    input ready);
    modport sink   (input valid, input halfwave_start, input peak_index,
                    input halfwave_end, input peak_magnitude, input last_in_run,
                    output ready);

endinterface

[src/clipping_halfwave_finder_unit.sv]
// ----------------------------------------------------------------------------
// clipping_halfwave_finder_unit
// Finds clipping half-waves in one channel of Q3.20 samples.
//
// Input beats carry one sample and a last_sample flag; the flag closes the
// channel and the next beat starts a new one at index 0. Output beats carry
// one record each (start, peak index, exclusive end, peak magnitude); a
// sample yields up to two records, last_in_run marks the final one.
// clip_threshold is written through i_cfg_we / i_cfg_wdata while idle;
// the user must keep to this, it is not enforced. One sample is taken per
// cycle while the queue is not full; each record goes through the job queue,
// then the output register. Output is limited to one record per cycle by the
// back part while the receiver is ready. A four-entry job queue decouples
// the sides: when the receiver stalls, samples that produce no record keep
// flowing and input ready drops only once the queue is full. Reset
// (synchronous, active low) empties the queue and output register, restores
// the threshold to 1.0 and starts a fresh channel.
// ----------------------------------------------------------------------------
module clipping_halfwave_finder_unit import chf_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    chf_in_if.sink                 i_in,
    chf_out_if.source              o_out,
    input  logic                   i_cfg_we,
    input  logic [THRESH_BITS-1:0] i_cfg_wdata
);

    logic   w_push;
    logic   w_pop;
    t_job   w_job;
    t_job   w_head;
    t_qstat w_qstat;

    chf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_qstat     (w_qstat),
        .o_push      (w_push),
        .o_job       (w_job)
    );

    chf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_qstat (w_qstat)
    );

    chf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .i_qstat (w_qstat),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

    a_push_has_rec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (w_job.cross_vld || w_job.end_vld))
        else $error("empty job pushed");

    a_queue_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_qstat.full && w_qstat.empty))
        else $error("queue both full and empty");

    a_rec_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.halfwave_start <= o_out.halfwave_end))
        else $error("record start beyond end");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_qstat.empty)
        else $error("pop from empty queue");

endmodule

[src/chf_front.sv]
// ----------------------------------------------------------------------------
// chf_front
// Accepts samples, tracks the half-wave state and builds record jobs.
// ----------------------------------------------------------------------------
module chf_front import chf_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    chf_in_if.sink                 i_in,
    input  logic                   i_cfg_we,
    input  logic [THRESH_BITS-1:0] i_cfg_wdata,
    input  t_qstat                 i_qstat,
    output logic                   o_push,
    output t_job                   o_job
);

    logic [THRESH_BITS-1:0] r_thr;
    logic                   r_first,   n_first;
    logic                   r_prevneg, n_prevneg;
    logic                   r_clip,    n_clip;
    logic [SAMPLE_BITS-1:0] r_peak,    n_peak;
    logic [INDEX_BITS-1:0]  r_ppos,    n_ppos;
    logic [INDEX_BITS-1:0]  r_start,   n_start;
    logic [INDEX_BITS-1:0]  r_cnt,     n_cnt;

    logic                   w_acc;
    logic                   w_neg;
    logic [SAMPLE_BITS-1:0] w_raw;
    logic [SAMPLE_BITS-1:0] w_mag;
    logic                   w_clips;
    logic [INDEX_BITS-1:0]  w_idx;

    assign i_in.ready = !i_qstat.full;
    assign w_acc      = i_in.valid && i_in.ready;

    always_comb begin
        w_raw   = i_in.sample;
        w_neg   = w_raw[SAMPLE_BITS-1];
        w_mag   = w_neg ? (~w_raw + 1'b1) : w_raw;
        w_clips = w_mag > {1'b0, r_thr};
        w_idx   = r_first ? '0 : r_cnt;

        n_first   = 1'b0;
        n_prevneg = r_prevneg;
        n_clip    = r_clip;
        n_peak    = r_peak;
        n_ppos    = r_ppos;
        n_start   = r_start;

        o_job.cross_vld = 1'b0;
        o_job.cross_rec = '{start_idx: r_start, peak_idx: r_ppos,
                            end_idx: w_idx, peak_mag: r_peak};

        if (r_first) begin
            n_peak    = w_mag;
            n_ppos    = '0;
            n_clip    = w_clips;
            n_prevneg = w_neg;
            n_start   = '0;
        end else begin
            if (w_neg != r_prevneg) begin
                o_job.cross_vld = r_clip;
                if (r_clip) begin
                    n_clip = 1'b0;
                    n_peak = '0;
                end
                n_start   = w_idx;
                n_prevneg = w_neg;
            end
            if (w_clips) begin
                n_clip = 1'b1;
                if (n_peak < w_mag) begin
                    n_peak = w_mag;
                    n_ppos = w_idx;
                end
            end
        end

        n_cnt = (w_idx == IDX_MAX) ? IDX_MAX : w_idx + 1'b1;

        o_job.end_vld = i_in.last_sample && n_clip;
        o_job.end_rec = '{start_idx: n_start, peak_idx: n_ppos,
                          end_idx: n_cnt, peak_mag: n_peak};

        if (i_in.last_sample) begin
            n_first   = 1'b1;
            n_prevneg = 1'b0;
            n_clip    = 1'b0;
            n_peak    = '0;
            n_ppos    = '0;
            n_start   = '0;
            n_cnt     = '0;
        end
    end

    assign o_push = w_acc && (o_job.cross_vld || o_job.end_vld);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr     <= THRESH_RESET;
            r_first   <= 1'b1;
            r_prevneg <= 1'b0;
            r_clip    <= 1'b0;
            r_peak    <= '0;
            r_ppos    <= '0;
            r_start   <= '0;
            r_cnt     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
            if (w_acc) begin
                r_first   <= n_first;
                r_prevneg <= n_prevneg;
                r_clip    <= n_clip;
                r_peak    <= n_peak;
                r_ppos    <= n_ppos;
                r_start   <= n_start;
                r_cnt     <= n_cnt;
            end
        end
    end

endmodule

[src/chf_queue.sv]
// ----------------------------------------------------------------------------
// chf_queue
// Small job FIFO between the front and back parts.
// ----------------------------------------------------------------------------
module chf_queue import chf_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_job   i_job,
    input  logic   i_pop,
    output t_job   o_head,
    output t_qstat o_qstat
);

    t_job                 r_mem [QDEPTH];
    logic [QPTR_BITS-1:0] r_wr, r_rd;
    logic [QCNT_BITS-1:0] r_cnt;
    logic                 w_push, w_pop;

    assign o_qstat.full  = (r_cnt == QCNT_BITS'(QDEPTH));
    assign o_qstat.empty = (r_cnt == '0);
    assign w_push        = i_push && !o_qstat.full;
    assign w_pop         = i_pop && !o_qstat.empty;
    assign o_head        = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == QPTR_BITS'(QDEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == QPTR_BITS'(QDEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

[src/chf_back.sv]
// ----------------------------------------------------------------------------
// chf_back
// Expands queued jobs into one or two records and holds the output register.
// ----------------------------------------------------------------------------
module chf_back import chf_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_job   i_head,
    input  t_qstat i_qstat,
    output logic   o_pop,
    chf_out_if.source o_out
);

    logic r_vld;
    logic r_sel, n_sel;
    t_rec r_rec;
    logic r_last;

    logic w_load;
    logic w_take;
    logic w_sel_end;
    logic w_last;
    t_rec w_rec;

    always_comb begin
        w_load    = !r_vld || o_out.ready;
        w_take    = w_load && !i_qstat.empty;
        w_sel_end = r_sel || !i_head.cross_vld;
        w_rec     = w_sel_end ? i_head.end_rec : i_head.cross_rec;
        w_last    = w_sel_end || !i_head.end_vld;
        o_pop     = w_take && w_last;
        n_sel     = w_take ? !w_last : r_sel;
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_rec  <= w_rec;
            r_last <= w_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_sel <= 1'b0;
        end else begin
            r_sel <= n_sel;
            if (w_load) begin
                r_vld <= !i_qstat.empty;
            end
        end
    end

    assign o_out.valid          = r_vld;
    assign o_out.halfwave_start = r_rec.start_idx;
    assign o_out.peak_index     = r_rec.peak_idx;
    assign o_out.halfwave_end   = r_rec.end_idx;
    assign o_out.peak_magnitude = r_rec.peak_mag;
    assign o_out.last_in_run    = r_last;

endmodule

[tb/clipping_halfwave_finder_unit_tb.sv]
// ----------------------------------------------------------------------------
// clipping_halfwave_finder_unit_tb
// Self-checking bench for the clipping half-wave finder. Sample beats come
// from a queue that a stimulus process fills (directed corner cases, then
// random channels shaped around the current threshold). A clocked predictor
// tracks each accepted sample and queues the records it should yield; the
// monitor compares every record beat field by field. Both handshake sides
// idle at random, the receiver once stalls long enough to back the block
// up, and the threshold is rewritten between phases, extremes included.
// ----------------------------------------------------------------------------
module clipping_halfwave_finder_unit_tb;
    import chf_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 6;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_SAMPLES = 115;
    localparam logic [THRESH_BITS-1:0] THRESH_MAX = '1;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] smp;
        logic                          lst;
    } sample_beat_t;

    typedef struct {
        logic [INDEX_BITS-1:0]  hw_start;
        logic [INDEX_BITS-1:0]  pk_idx;
        logic [INDEX_BITS-1:0]  hw_end;
        logic [SAMPLE_BITS-1:0] pk_mag;
        logic                   tail;
    } halfwave_rec_t;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [THRESH_BITS-1:0] i_cfg_wdata;

    chf_in_if  in_if ();
    chf_out_if out_if ();

    clipping_halfwave_finder_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_if),
        .o_out       (out_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    sample_beat_t  samples_to_send[$];
    halfwave_rec_t halfwave_records_due[$];

    int  src_idle_pct;
    int  sink_idle_pct;
    bit  sink_hold;
    bit  hold_go;
    bit  in_beat;
    int  mismatches;
    int  stall_cycles;
    int  cur_thr;

    // predictor state
    logic [THRESH_BITS-1:0] thr_model;
    logic                   ch_fresh;
    logic                   was_neg;
    logic                   clipped;
    logic [SAMPLE_BITS-1:0] peak_mag;
    logic [INDEX_BITS-1:0]  peak_pos;
    logic [INDEX_BITS-1:0]  hw_begin;
    logic [INDEX_BITS-1:0]  next_idx;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic void clear_channel_model();
        ch_fresh = 1'b1;
        was_neg  = 1'b0;
        clipped  = 1'b0;
        peak_mag = '0;
        peak_pos = '0;
        hw_begin = '0;
        next_idx = '0;
    endfunction

    function automatic halfwave_rec_t make_rec(input logic [INDEX_BITS-1:0] stop_idx);
        halfwave_rec_t r;
        r.hw_start = hw_begin;
        r.pk_idx   = peak_pos;
        r.hw_end   = stop_idx;
        r.pk_mag   = peak_mag;
        r.tail     = 1'b0;
        return r;
    endfunction

    function automatic void track_halfwave(input logic [SAMPLE_BITS-1:0] raw, input logic lst);
        logic                   neg;
        logic [SAMPLE_BITS-1:0] mag;
        logic                   clips;
        logic [INDEX_BITS-1:0]  idx;
        halfwave_rec_t          recs[2];
        int                     n;
        neg   = raw[SAMPLE_BITS-1];
        mag   = neg ? -raw : raw;
        clips = mag > {1'b0, thr_model};
        n     = 0;
        if (ch_fresh) begin
            idx      = '0;
            ch_fresh = 1'b0;
            peak_mag = mag;
            peak_pos = '0;
            clipped  = clips;
            was_neg  = neg;
            hw_begin = '0;
        end else begin
            idx = next_idx;
            if (neg != was_neg) begin
                if (clipped) begin
                    recs[n] = make_rec(idx);
                    n++;
                    clipped  = 1'b0;
                    peak_mag = '0;
                end
                hw_begin = idx;
                was_neg  = neg;
            end
            if (clips) begin
                clipped = 1'b1;
                if (peak_mag < mag) begin
                    peak_mag = mag;
                    peak_pos = idx;
                end
            end
        end
        next_idx = (idx == IDX_MAX) ? IDX_MAX : idx + 1'b1;
        if (lst) begin
            if (clipped) begin
                recs[n] = make_rec(next_idx);
                n++;
            end
            clear_channel_model();
        end
        for (int k = 0; k < n; k++) begin
            recs[k].tail = (k == n - 1);
            halfwave_records_due.push_back(recs[k]);
        end
    endfunction

    function automatic void check_field(input string name, input logic [INDEX_BITS-1:0] want,
                                        input logic [INDEX_BITS-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // driver: sample beats
    always @(negedge i_clk) begin : sample_driver
        sample_beat_t b;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || in_beat) begin
            if (samples_to_send.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                b = samples_to_send.pop_front();
                in_if.valid       <= 1'b1;
                in_if.sample      <= b.smp;
                in_if.last_sample <= b.lst;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // driver: record ready
    always @(negedge i_clk) begin : record_ready_driver
        out_if.ready <= !sink_hold && ($urandom_range(99) >= sink_idle_pct);
    end

    // monitor: prediction, record check, watchdog
    always @(posedge i_clk) begin : monitor
        halfwave_rec_t want;
        if (!i_rst_n) begin
            thr_model = THRESH_RESET;
            clear_channel_model();
            in_beat      <= 1'b0;
            stall_cycles = 0;
        end else begin
            in_beat <= in_if.valid && in_if.ready;
            if (out_if.valid && out_if.ready) begin
                if (halfwave_records_due.size() == 0) begin
                    $error("unexpected record beat: start %0d peak %0d end %0d mag %0d",
                           out_if.halfwave_start, out_if.peak_index,
                           out_if.halfwave_end, out_if.peak_magnitude);
                    mismatches++;
                end else begin
                    want = halfwave_records_due.pop_front();
                    check_field("halfwave_start", want.hw_start, out_if.halfwave_start);
                    check_field("peak_index", want.pk_idx, out_if.peak_index);
                    check_field("halfwave_end", want.hw_end, out_if.halfwave_end);
                    check_field("peak_magnitude", INDEX_BITS'(want.pk_mag),
                                INDEX_BITS'(out_if.peak_magnitude));
                    check_field("last_in_run", INDEX_BITS'(want.tail),
                                INDEX_BITS'(out_if.last_in_run));
                end
            end
            if (in_if.valid && in_if.ready)
                track_halfwave(in_if.sample, in_if.last_sample);
            if (i_cfg_we)
                thr_model = i_cfg_wdata;
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
                if (stall_cycles >= STALL_LIMIT) begin
                    $display("timeout: no beat for %0d cycles", STALL_LIMIT);
                    $display("*** FAILED ***");
                    $finish;
                end
            end
        end
    end

    // long receiver stall so the job queue fills and input ready drops
    initial begin : record_stall
        sink_hold = 1'b0;
        wait (hold_go);
        @(posedge i_clk);
        sink_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        sink_hold = 1'b0;
    end

    function automatic void send(input int v, input bit lst);
        sample_beat_t b;
        b.smp = SAMPLE_BITS'(v);
        b.lst = lst;
        samples_to_send.push_back(b);
    endfunction

    function automatic int pick_magnitude(input int thr);
        int m;
        case ($urandom_range(9))
            0:       m = 0;
            1:       m = 1 << (SAMPLE_BITS - 1);
            2, 3, 4: m = thr + int'($urandom_range(6)) - 3;
            5, 6, 7: m = thr + 1 + int'($urandom_range((1 << (SAMPLE_BITS - 1)) - 1 - thr));
            default: m = int'($urandom_range(1 << (SAMPLE_BITS - 1)));
        endcase
        if (m < 0)
            m = 0;
        if (m > (1 << (SAMPLE_BITS - 1)))
            m = 1 << (SAMPLE_BITS - 1);
        return m;
    endfunction

    // one channel of alternating half-waves, with some raw noise samples
    function automatic int add_channel(input int len);
        bit neg;
        int run;
        int m;
        neg = 1'($urandom_range(1));
        run = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
            if (run == 0) begin
                neg = !neg;
                run = $urandom_range(1, 6);
            end
            run--;
            if ($urandom_range(7) == 0) begin
                send(int'($urandom), i == len - 1);
            end else begin
                m = pick_magnitude(cur_thr);
                if (neg)
                    send(-m, i == len - 1);
                else
                    send((m > (1 << (SAMPLE_BITS - 1)) - 1) ? (1 << (SAMPLE_BITS - 1)) - 1 : m,
                         i == len - 1);
            end
        end
        return len;
    endfunction

    function automatic void add_channels(input int target);
        int n;
        n = 0;
        while (n < target)
            n += add_channel(($urandom_range(5) == 0) ? 1 : $urandom_range(2, 40));
    endfunction

    task automatic settle();
        while (samples_to_send.size() != 0 || in_if.valid || halfwave_records_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_threshold(input logic [THRESH_BITS-1:0] value);
        settle();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cur_thr = int'(value);
        @(posedge i_clk);
    endtask

    initial begin : stimulus
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_wdata       = '0;
        in_if.valid       = 1'b0;
        in_if.sample      = '0;
        in_if.last_sample = 1'b0;
        out_if.ready      = 1'b0;
        hold_go           = 1'b0;
        mismatches        = 0;
        src_idle_pct      = 15;
        sink_idle_pct     = 84;
        cur_thr           = int'(THRESH_RESET);
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single-sample channels, clipping and not
        send(2097152, 1);
        send(0, 1);
        // most negative first sample, full-scale peaks, threshold equality,
        // zero as non-negative, crossing and end records from one beat
        send(-8388608, 0);
        send(1, 0);
        send(8388607, 0);
        send(1048576, 0);
        send(1048577, 0);
        send(-1, 0);
        send(0, 0);
        send(3000000, 0);
        send(-1048577, 1);
        // non-clipping first peak held across quiet crossings, equal peaks
        send(500000, 0);
        send(-500000, 0);
        send(600000, 0);
        send(-1048600, 0);
        send(-1048600, 0);
        send(5, 1);
        // stale peak after a threshold change mid-channel
        set_threshold(THRESH_MAX);
        send(4194304, 0);
        set_threshold(THRESH_RESET);
        send(2097152, 0);
        send(-1, 1);

        set_threshold(THRESH_BITS'($urandom_range(1 << 20, 3 << 20)));
        add_channels(PHASE_SAMPLES);
        set_threshold('0);
        add_channels(PHASE_SAMPLES);

        settle();
        src_idle_pct  = 84;
        sink_idle_pct = 15;
        set_threshold(THRESH_MAX);
        add_channels(PHASE_SAMPLES);
        set_threshold(THRESH_BITS'($urandom_range(THRESH_MAX)));
        add_channels(PHASE_SAMPLES);

        settle();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        set_threshold(THRESH_BITS'($urandom_range(1, 1 << 20)));
        add_channels(PHASE_SAMPLES);
        hold_go = 1'b1;

        settle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && halfwave_records_due.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[filelist.f]
src/chf_pkg.sv
src/chf_in_if.sv
src/chf_out_if.sv
src/chf_front.sv
src/chf_queue.sv
src/chf_back.sv
src/clipping_halfwave_finder_unit.sv
tb/clipping_halfwave_finder_unit_tb.sv
